### rtl/sbi_pkg.sv
// shared types and constants for the stack with bottom increment
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbi_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned CfgW         = 11;
  localparam int unsigned DefaultDepth = 1024;

  localparam logic [CfgW-1:0] CapacityReset = 11'd1024;
  localparam logic [DataW-1:0] EmptyWord    = '1;

  typedef enum logic [1:0] {
    CmdPush = 2'd0,
    CmdPop  = 2'd1,
    CmdInc  = 2'd2
  } cmd_e;

  // broadcast to every cell of the row, in the cycle after a transfer
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             inc;
    logic [DataW-1:0] amount;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/sbi_cell.sv
// one stack cell: holds a word, shifts with its neighbours, adds on increment
// depends on sbi_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbi_cell import sbi_pkg::*; #(
  parameter int unsigned IdxW = 11,
  parameter int unsigned Pos  = 0
) (
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [IdxW-1:0]  lo_i,
  input  wire logic [DataW-1:0] from_above_i,
  input  wire logic [DataW-1:0] from_below_i,
  output      logic [DataW-1:0] value_o
);

  logic [DataW-1:0] value_d, value_q;
  logic             in_range;

  assign in_range = IdxW'(Pos) >= lo_i;

  always_comb begin
    priority if (ctrl_i.push) begin
      value_d = from_above_i;
    end else if (ctrl_i.pop) begin
      value_d = from_below_i;
    end else if (ctrl_i.inc && in_range) begin
      value_d = value_q + ctrl_i.amount;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

### rtl/stack_with_bottom_increment_core.sv
// top level of the stack with bottom increment: command decode, fill level,
// capacity register and a row of sbi_cell instances; depends on sbi_pkg and sbi_cell
//
// usage
//   a command transfers at a rising edge where start is high and busy is low.
//   busy is high in the cycle after a transfer, in which the whole row of
//   cells shifts or adds after the command is decoded in the transfer cycle;
//   no new command is taken while busy. push and increment give no result.
//   pop gives one result: popped_value_o and was_empty_o are shown for
//   exactly one cycle with result_valid_o high, in the cycle after busy. the
//   receiver cannot stall, so the result is taken at the edge that ends that
//   cycle. the stack is a row of DEPTH cells with the top word in cell 0; a
//   push shifts the row down, a pop shifts it up, and an increment adds the
//   amount in every cell at or below the bottom-count boundary, all in the
//   same cycle. capacity is written by capacity_we_i; the user must write it
//   only while no command is in progress, as the block does not enforce it.
//   reset empties the stack, sets capacity to 1024 and drops any pending
//   result; no clearing pass is needed, the cell words hold no reset value.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_bottom_increment_core import sbi_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             capacity_we_i,
  input  wire logic [CfgW-1:0]  capacity_i,
  input  wire logic             start,
  output      logic             busy,
  input  wire logic [1:0]       command_i,
  input  wire logic [DataW-1:0] operand_value_i,
  input  wire logic [CfgW-1:0]  bottom_count_i,
  output      logic             result_valid_o,
  output      logic [DataW-1:0] popped_value_o,
  output      logic             was_empty_o
);

  localparam int unsigned FillW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (FillW > CfgW) ? FillW : CfgW;

  logic [CfgW-1:0]  capacity_q;
  logic [FillW-1:0] fill_d, fill_q;
  logic             busy_q;
  cell_ctrl_t       ctrl_d, ctrl_q;
  logic             empty_d, empty_q;
  logic [FillW-1:0] lo_d, lo_q;
  logic             valid_q;
  logic [DataW-1:0] popped_q;
  logic             was_empty_q;
  logic             accept;

  logic [CmpW-1:0]  cap_ext, depth_ext, cap_eff, fill_ext, cnt_ext, n_eff, lo_ext;
  cmd_e             cmd;

  logic [DataW-1:0] cell_value [DEPTH];

  assign accept = start && !busy_q;
  assign cmd    = cmd_e'(command_i);

  assign cap_ext   = CmpW'(capacity_q);
  assign depth_ext = CmpW'(DEPTH);
  assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign fill_ext  = CmpW'(fill_q);
  assign cnt_ext   = CmpW'(bottom_count_i);
  assign n_eff     = (cnt_ext < fill_ext) ? cnt_ext : fill_ext;
  assign lo_ext    = fill_ext - n_eff;

  // decode
  always_comb begin
    ctrl_d        = '0;
    ctrl_d.amount = operand_value_i;
    empty_d       = 1'b0;
    fill_d        = fill_q;
    lo_d          = FillW'(lo_ext);
    if (accept) begin
      unique case (cmd)
        CmdPush: begin
          if (fill_ext < cap_eff) begin
            ctrl_d.push = 1'b1;
            fill_d      = fill_q + FillW'(1);
          end
        end
        CmdPop: begin
          if (fill_q != '0) begin
            ctrl_d.pop = 1'b1;
            fill_d     = fill_q - FillW'(1);
          end else begin
            empty_d = 1'b1;
          end
        end
        CmdInc: begin
          ctrl_d.inc = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
      fill_q     <= '0;
      busy_q     <= 1'b0;
      ctrl_q     <= '0;
      empty_q    <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      if (capacity_we_i) begin
        capacity_q <= capacity_i;
      end
      fill_q  <= fill_d;
      busy_q  <= accept;
      ctrl_q  <= ctrl_d;
      empty_q <= empty_d;
      valid_q <= ctrl_q.pop || empty_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    if (ctrl_q.pop) begin
      popped_q    <= cell_value[0];
      was_empty_q <= 1'b0;
    end else if (empty_q) begin
      popped_q    <= EmptyWord;
      was_empty_q <= 1'b1;
    end
  end

  // row of cells, top of stack in cell 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] above, below;
    if (g == 0) begin : g_top
      assign above = ctrl_q.amount;
    end else begin : g_mid_above
      assign above = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_bottom
      assign below = cell_value[g];
    end else begin : g_mid_below
      assign below = cell_value[g+1];
    end
    sbi_cell #(
      .IdxW(FillW),
      .Pos (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_q),
      .lo_i        (lo_q),
      .from_above_i(above),
      .from_below_i(below),
      .value_o     (cell_value[g])
    );
  end

  assign busy           = busy_q;
  assign result_valid_o = valid_q;
  assign popped_value_o = popped_q;
  assign was_empty_o    = was_empty_q;

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("busy held for more than one cycle");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(busy_q))
    else $error("result without a command in progress");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(fill_q) <= depth_ext)
    else $error("fill level above depth");

  a_one_row_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ctrl_q.push, ctrl_q.pop, ctrl_q.inc, empty_q}) <= 1)
    else $error("more than one row operation at once");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && was_empty_q) |-> (popped_q == EmptyWord))
    else $error("empty pop without all-ones word");

endmodule

`default_nettype wire

### tb/sbi_tb_pkg.sv
// scoreboard for the stack with bottom increment: a mirror of the stack that
// predicts each pop and checks it against the block; depends on sbi_pkg
`timescale 1ns / 1ps

package sbi_tb_pkg;

  import sbi_pkg::*;

  // unused command code, the block ignores it
  localparam logic [1:0] CmdSpare = 2'd3;

  class stack_mirror;
    logic [DataW-1:0] words [DefaultDepth];
    int unsigned      level;
    logic [CfgW-1:0]  capacity;
    logic [DataW-1:0] due_word [$];
    logic             due_empty [$];
    int unsigned      errors;
    int unsigned      seen;

    function new();
      level    = 0;
      capacity = CapacityReset;
      errors   = 0;
      seen     = 0;
    endfunction

    function int unsigned pending();
      return due_word.size();
    endfunction

    function void flag(string what, logic [DataW-1:0] want, logic [DataW-1:0] got);
      errors++;
      if (errors <= 10) begin
        $display("mismatch at pop %0d: %s expected %h actual %h", seen, what, want, got);
      end
    endfunction

    // one accepted command transfer
    function void note_command(logic [1:0] cmd, logic [DataW-1:0] word,
                               logic [CfgW-1:0] count);
      int unsigned room;
      int unsigned span;
      room = (capacity > DefaultDepth) ? DefaultDepth : capacity;
      case (cmd)
        CmdPush: begin
          if (level < room) begin
            words[level] = word;
            level++;
          end
        end
        CmdPop: begin
          if (level == 0) begin
            due_word.push_back(EmptyWord);
            due_empty.push_back(1'b1);
          end else begin
            level--;
            due_word.push_back(words[level]);
            due_empty.push_back(1'b0);
          end
        end
        CmdInc: begin
          span = (count < level) ? count : level;
          for (int i = 0; i < span; i++) words[i] = words[i] + word;
        end
        default: ;
      endcase
    endfunction

    // one pop result transfer
    function void check_pop(logic [DataW-1:0] word, logic empty);
      logic [DataW-1:0] want_word;
      logic             want_empty;
      seen++;
      if (due_word.size() == 0) begin
        flag("result with no pop outstanding, word", 'x, word);
        return;
      end
      want_word  = due_word.pop_front();
      want_empty = due_empty.pop_front();
      if (word !== want_word) flag("popped_value", want_word, word);
      if (empty !== want_empty) flag("was_empty", want_empty, empty);
    endfunction

    function void close();
      while (due_word.size() != 0) begin
        flag("pop result never seen, word", due_word.pop_front(), 'x);
        void'(due_empty.pop_front());
      end
    endfunction
  endclass

endpackage

### tb/tb_top.sv
// top of the stack with bottom increment testbench: clock, reset, command
// driver and monitor; depends on sbi_pkg, sbi_tb_pkg and the core
`timescale 1ns / 1ps

module tb_top;

  import sbi_pkg::*;
  import sbi_tb_pkg::*;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             capacity_we_i   = 1'b0;
  logic [CfgW-1:0]  capacity_i      = '0;
  logic             start           = 1'b0;
  logic             busy;
  logic [1:0]       command_i       = CmdPush;
  logic [DataW-1:0] operand_value_i = '0;
  logic [CfgW-1:0]  bottom_count_i  = '0;
  logic             result_valid_o;
  logic [DataW-1:0] popped_value_o;
  logic             was_empty_o;

  stack_mirror mirror = new();

  stack_with_bottom_increment_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .capacity_we_i   (capacity_we_i),
    .capacity_i      (capacity_i),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .operand_value_i (operand_value_i),
    .bottom_count_i  (bottom_count_i),
    .result_valid_o  (result_valid_o),
    .popped_value_o  (popped_value_o),
    .was_empty_o     (was_empty_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("stack_with_bottom_increment_core test failed");
    $finish;
  end

  // result first, then any new command at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) mirror.check_pop(popped_value_o, was_empty_o);
      if (start && !busy) mirror.note_command(command_i, operand_value_i, bottom_count_i);
    end
  end

  task automatic issue(input logic [1:0] cmd, input logic [DataW-1:0] word,
                       input logic [CfgW-1:0] count);
    start           <= 1'b1;
    command_i       <= cmd;
    operand_value_i <= word;
    bottom_count_i  <= count;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CfgW-1:0] value);
    drain();
    capacity_we_i <= 1'b1;
    capacity_i    <= value;
    @(posedge clk_i);
    capacity_we_i <= 1'b0;
    mirror.capacity = value;
  endtask

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return EmptyWord;
      3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 11'd1024;
      3: return CfgW'($urandom_range(0, 2047));
      default: return (mirror.level + 2 > 2047) ? 11'd2047 :
                      CfgW'($urandom_range(0, mirror.level + 2));
    endcase
  endfunction

  function automatic logic [1:0] pick_command(int unsigned push_pct, int unsigned pop_pct,
                                              int unsigned inc_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return CmdPush;
    if (r < push_pct + pop_pct) return CmdPop;
    if (r < push_pct + pop_pct + inc_pct) return CmdInc;
    return CmdSpare;
  endfunction

  task automatic run_mix(input int unsigned items, input int unsigned push_pct,
                         input int unsigned pop_pct, input int unsigned inc_pct,
                         input bit quiet);
    int unsigned gap_pct;
    gap_pct = 0;
    for (int n = 0; n < items; n++) begin
      if (n % 32 == 0) gap_pct = quiet ? 0 : 20 * $urandom_range(0, 2);
      issue(pick_command(push_pct, pop_pct, inc_pct), pick_word(), pick_count());
      if (!quiet && $urandom_range(0, 149) == 0) drain();
      else if ($urandom_range(0, 99) < gap_pct) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty stack, wrap-around, counts of zero and beyond the fill level
    issue(CmdPop, '0, '0);
    issue(CmdSpare, 32'hffff_ffff, '1);
    issue(CmdInc, 32'd5, 11'd5);
    issue(CmdPush, 32'h7fff_ffff, '0);
    issue(CmdPush, 32'h8000_0000, '1);
    issue(CmdPush, 32'h0000_0000, '0);
    issue(CmdPush, 32'hffff_ffff, '0);
    issue(CmdInc, 32'd1, 11'd2);
    issue(CmdInc, 32'd5, 11'd0);
    issue(CmdInc, 32'h8000_0000, 11'd2047);
    issue(CmdInc, 32'hffff_ffff, 11'd1024);
    issue(CmdSpare, 32'h1234_5678, 11'd3);
    issue(CmdPop, '0, '0);
    issue(CmdPop, '0, '0);
    issue(CmdPop, '0, '0);
    issue(CmdPop, '0, '0);
    issue(CmdPop, '0, '0);
    issue(CmdPush, 32'h5555_5555, 11'h2aa);
    issue(CmdPop, 32'haaaa_aaaa, 11'h555);
    write_capacity(11'd0);
    issue(CmdPush, 32'h0bad_cafe, '0);
    issue(CmdPop, '0, '0);

    // small capacities keep the stack near full
    write_capacity(11'd3);
    run_mix(150, 45, 35, 15, 1'b0);
    write_capacity(11'd1);
    run_mix(80, 45, 35, 15, 1'b0);

    // capacity above the depth: fill the whole row
    write_capacity(11'd2047);
    run_mix(1100, 96, 2, 1, 1'b0);

    // capacity below the fill level: pushes ignored until pops catch up
    write_capacity(11'd900);
    run_mix(300, 15, 70, 12, 1'b0);

    write_capacity(11'd1024);
    run_mix(100, 40, 40, 15, 1'b1);

    start <= 1'b0;
    for (int w = 0; w < 200 && mirror.pending() != 0; w++) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    mirror.close();
    if (mirror.errors == 0) begin
      $display("stack_with_bottom_increment_core test passed");
    end else begin
      $display("stack_with_bottom_increment_core test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sbi_pkg.sv
rtl/sbi_cell.sv
rtl/stack_with_bottom_increment_core.sv
tb/sbi_tb_pkg.sv
tb/tb_top.sv
